[hw/rtl/srs_pkg.sv]
`timescale 1ns / 1ps

package srs_pkg;

	localparam int LEAF_COUNT    = 1024;
	localparam int OPERAND_WIDTH = 32;
	localparam int SUM_W         = 42;
	localparam int FUNC_W        = 2;
	localparam int LEAF_W        = 10;
	localparam int RANGE_W       = 11;

	// heap layout: root at node 1, leaf k at node TREE_SPAN + k
	localparam int LEVELS     = $clog2(LEAF_COUNT);
	localparam int TREE_SPAN  = 1 << LEVELS;
	localparam int NODE_DEPTH = 2 * TREE_SPAN;
	localparam int NODE_W     = LEVELS + 1;
	// query pointers reach 2 * TREE_SPAN
	localparam int PTR_W      = LEVELS + 2;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_SET   = 2'd0,
		FUNC_ADD   = 2'd1,
		FUNC_QUERY = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef struct packed {
		logic              en;
		logic [NODE_W-1:0] addr;
		logic [SUM_W-1:0]  data;
	} ram_wr_t;

	typedef struct packed {
		logic              en;
		logic [NODE_W-1:0] addr;
	} ram_rd_t;

endpackage

[hw/rtl/srs_node_ram.sv]
`timescale 1ns / 1ps

module srs_node_ram (
	input  logic                       clk,
	input  srs_pkg::ram_wr_t           wr,
	input  srs_pkg::ram_rd_t           rd,
	output logic [srs_pkg::SUM_W-1:0]  rd_data
);

	logic [srs_pkg::SUM_W-1:0] node_mem [srs_pkg::NODE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			node_mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= node_mem[rd.addr];
		end
	end

endmodule

[hw/rtl/segment_tree_range_sum_unit.sv]
`timescale 1ns / 1ps
// set: the leaf is written, then each ancestor up to the root; add: the same after a read of the
// old leaf, which is added to the operand. query: a left and a right step per tree level walked,
// then a final step that waits for a free output. One item at a time, over the one-read one-write
// node memory and its shared adder. After arst_n is released a clearing pass writes all 2048
// nodes to zero, during which no item is accepted

module segment_tree_range_sum_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [srs_pkg::FUNC_W-1:0]             func,
	input  logic [srs_pkg::LEAF_W-1:0]             leaf_index,
	input  logic signed [srs_pkg::OPERAND_WIDTH-1:0] operand,
	input  logic [srs_pkg::RANGE_W-1:0]            range_lo,
	input  logic [srs_pkg::RANGE_W-1:0]            range_hi,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [srs_pkg::SUM_W-1:0]       range_sum
);

	localparam logic [srs_pkg::NODE_W-1:0] SPAN_NODE = srs_pkg::NODE_W'(srs_pkg::TREE_SPAN);
	localparam logic [srs_pkg::NODE_W-1:0] ROOT_NODE = srs_pkg::NODE_W'(1);
	localparam logic [srs_pkg::PTR_W-1:0]  SPAN_PTR  = srs_pkg::PTR_W'(srs_pkg::TREE_SPAN);
	localparam logic [srs_pkg::RANGE_W-1:0] LEAF_LIM = srs_pkg::RANGE_W'(srs_pkg::LEAF_COUNT);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD_WAIT,
		ST_WRITE_LEAF,
		ST_UP_ADD,
		ST_Q_L,
		ST_Q_R,
		ST_Q_FIN
	} state_t;

	state_t                        state_q;
	logic [srs_pkg::NODE_W-1:0]    clr_q;
	logic [srs_pkg::NODE_W-1:0]    node_q;
	logic [srs_pkg::PTR_W-1:0]     l_q;
	logic [srs_pkg::PTR_W-1:0]     r_q;
	logic [srs_pkg::SUM_W-1:0]     acc_q;
	logic                          pend_q;
	logic                          out_valid_q;
	logic [srs_pkg::SUM_W-1:0]     range_sum_q;

	srs_pkg::ram_wr_t              ram_wr;
	srs_pkg::ram_rd_t              ram_rd;
	logic [srs_pkg::SUM_W-1:0]     rd_data;

	logic                          accept;
	logic                          use_rd;
	logic [srs_pkg::SUM_W-1:0]     sum;
	logic [srs_pkg::SUM_W-1:0]     operand_ext;
	logic [srs_pkg::NODE_W-1:0]    leaf_node;
	logic [srs_pkg::NODE_W-1:0]    parent;
	logic                          leaf_ok;
	logic [srs_pkg::RANGE_W-1:0]   lo_c;
	logic [srs_pkg::RANGE_W-1:0]   hi_c;
	logic                          out_free;

	srs_node_ram u_node_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd      (ram_rd),
		.rd_data (rd_data)
	);

	assign in_ready    = (state_q == ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign out_valid   = out_valid_q;
	assign range_sum   = range_sum_q;
	assign out_free    = !out_valid_q || out_ready;

	assign operand_ext = {{(srs_pkg::SUM_W - srs_pkg::OPERAND_WIDTH)
	                       {operand[srs_pkg::OPERAND_WIDTH-1]}}, operand};
	assign leaf_node   = SPAN_NODE + srs_pkg::NODE_W'(leaf_index);
	assign leaf_ok     = int'(leaf_index) < srs_pkg::LEAF_COUNT;
	assign parent      = node_q >> 1;
	assign lo_c        = (range_lo > LEAF_LIM) ? LEAF_LIM : range_lo;
	assign hi_c        = (range_hi > LEAF_LIM) ? LEAF_LIM : range_hi;

	// the one adder: read data from the previous cycle folds into the accumulator
	assign use_rd = (state_q == ST_ADD_WAIT) || (state_q == ST_UP_ADD) || pend_q;
	assign sum    = acc_q + (use_rd ? rd_data : '0);

	always_comb begin
		ram_wr = '0;
		ram_rd = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_wr.en   = 1'b1;
				ram_wr.addr = clr_q;
			end
			ST_IDLE: begin
				if (accept && func == srs_pkg::FUNC_ADD && leaf_ok) begin
					ram_rd.en   = 1'b1;
					ram_rd.addr = leaf_node;
				end
			end
			ST_WRITE_LEAF: begin
				ram_wr.en   = 1'b1;
				ram_wr.addr = node_q;
				ram_wr.data = acc_q;
				ram_rd.en   = (node_q != ROOT_NODE);
				ram_rd.addr = node_q ^ ROOT_NODE;
			end
			ST_UP_ADD: begin
				ram_wr.en   = 1'b1;
				ram_wr.addr = parent;
				ram_wr.data = sum;
				ram_rd.en   = (parent != ROOT_NODE);
				ram_rd.addr = parent ^ ROOT_NODE;
			end
			ST_Q_L: begin
				ram_rd.en   = (l_q < r_q) && l_q[0];
				ram_rd.addr = l_q[srs_pkg::NODE_W-1:0];
			end
			ST_Q_R: begin
				ram_rd.en   = r_q[0];
				ram_rd.addr = {r_q[srs_pkg::NODE_W-1:1], 1'b0};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			node_q      <= '0;
			l_q         <= '0;
			r_q         <= '0;
			acc_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			range_sum_q <= '0;
		end else begin
			if (use_rd) begin
				acc_q <= sum;
			end
			if (state_q == ST_Q_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						node_q <= leaf_node;
						case (func)
							srs_pkg::FUNC_SET: begin
								acc_q <= operand_ext;
								if (leaf_ok) begin
									state_q <= ST_WRITE_LEAF;
								end
							end
							srs_pkg::FUNC_ADD: begin
								acc_q <= operand_ext;
								if (leaf_ok) begin
									state_q <= ST_ADD_WAIT;
								end
							end
							srs_pkg::FUNC_QUERY: begin
								acc_q <= '0;
								l_q   <= srs_pkg::PTR_W'(lo_c) + SPAN_PTR;
								r_q   <= srs_pkg::PTR_W'(hi_c) + SPAN_PTR;
								state_q <= (lo_c < hi_c) ? ST_Q_L : ST_Q_FIN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_ADD_WAIT: begin
					state_q <= ST_WRITE_LEAF;
				end
				ST_WRITE_LEAF: begin
					state_q <= (node_q == ROOT_NODE) ? ST_IDLE : ST_UP_ADD;
				end
				ST_UP_ADD: begin
					node_q <= parent;
					if (parent == ROOT_NODE) begin
						state_q <= ST_IDLE;
					end
				end
				ST_Q_L: begin
					pend_q <= (l_q < r_q) && l_q[0];
					if (l_q >= r_q) begin
						state_q <= ST_Q_FIN;
					end else begin
						if (l_q[0]) begin
							l_q <= l_q + 1'b1;
						end
						state_q <= ST_Q_R;
					end
				end
				ST_Q_R: begin
					// an odd right end drops to r - 1, which shifts to the same parent
					pend_q  <= r_q[0];
					l_q     <= l_q >> 1;
					r_q     <= r_q >> 1;
					state_q <= ST_Q_L;
				end
				ST_Q_FIN: begin
					if (out_free) begin
						range_sum_q <= sum;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// a pending add always follows a memory read issued the cycle before
	a_pend_has_read: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> $past(ram_rd.en))
		else $error("accumulate without a preceding read");

	// each ancestor write lands on the parent of the sibling just read
	a_up_parent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UP_ADD) |-> (ram_wr.addr == ($past(ram_rd.addr) >> 1)))
		else $error("ancestor write address off the path");

	// queries never modify the tree
	a_query_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_Q_L || state_q == ST_Q_R || state_q == ST_Q_FIN) |-> !ram_wr.en)
		else $error("tree written during a query");

	// a result beat is only raised out of the final query state
	a_result_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_Q_FIN))
		else $error("result beat without a query");
`endif

endmodule

[tb/segment_tree_range_sum_checker.sv]
`timescale 1ns / 1ps

module segment_tree_range_sum_checker (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	input  logic                                     in_ready,
	input  logic [srs_pkg::FUNC_W-1:0]               func,
	input  logic [srs_pkg::LEAF_W-1:0]               leaf_index,
	input  logic signed [srs_pkg::OPERAND_WIDTH-1:0] operand,
	input  logic [srs_pkg::RANGE_W-1:0]              range_lo,
	input  logic [srs_pkg::RANGE_W-1:0]              range_hi,
	input  logic                                     out_valid,
	input  logic                                     out_ready,
	input  logic signed [srs_pkg::SUM_W-1:0]         range_sum,
	output int                                       fail_count,
	output int                                       open_queries,
	output int                                       query_count,
	output int                                       sum_count
);

	// leaf values at node width; any node sum is the wrapped sum of its leaves
	logic signed [srs_pkg::SUM_W-1:0] leaf_val [srs_pkg::LEAF_COUNT];
	logic signed [srs_pkg::SUM_W-1:0] pending_sums [$];

	always @(posedge clk or negedge arst_n) begin : track
		logic signed [srs_pkg::SUM_W-1:0] widened;
		logic signed [srs_pkg::SUM_W-1:0] total;
		logic signed [srs_pkg::SUM_W-1:0] wanted;
		int lo_c;
		int hi_c;
		if (!arst_n) begin
			for (int k = 0; k < srs_pkg::LEAF_COUNT; k++)
				leaf_val[k] = '0;
			pending_sums.delete();
			fail_count   = 0;
			open_queries = 0;
			query_count  = 0;
			sum_count    = 0;
		end else begin
			// result beats belong to earlier queries, so retire them first
			if (out_valid && out_ready) begin
				sum_count++;
				if (pending_sums.size() == 0) begin
					$error("range_sum: result beat with no query outstanding, got %0d",
						range_sum);
					fail_count++;
				end else begin
					wanted = pending_sums.pop_front();
					if (range_sum !== wanted) begin
						$error("range_sum: expected %0d, got %0d", wanted, range_sum);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				widened = srs_pkg::SUM_W'(operand);
				case (srs_pkg::func_t'(func))
					srs_pkg::FUNC_SET: leaf_val[leaf_index] = widened;
					srs_pkg::FUNC_ADD: leaf_val[leaf_index] = leaf_val[leaf_index] + widened;
					srs_pkg::FUNC_QUERY: begin
						lo_c = (range_lo > srs_pkg::LEAF_COUNT) ? srs_pkg::LEAF_COUNT
							: int'(range_lo);
						hi_c = (range_hi > srs_pkg::LEAF_COUNT) ? srs_pkg::LEAF_COUNT
							: int'(range_hi);
						total = '0;
						for (int k = lo_c; k < hi_c; k++)
							total = total + leaf_val[k];
						pending_sums = {pending_sums, total};
						query_count++;
					end
					default: ;
				endcase
			end
			open_queries = pending_sums.size();
		end
	end

endmodule

[tb/segment_tree_range_sum_unit_test.sv]
`timescale 1ns / 1ps

module segment_tree_range_sum_unit_test;

	localparam int RANDOM_ITEMS = 280;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;

	logic                                     clk        = 1'b0;
	logic                                     arst_n     = 1'b0;
	logic                                     in_valid   = 1'b0;
	logic                                     in_ready;
	logic [srs_pkg::FUNC_W-1:0]               func       = srs_pkg::FUNC_SET;
	logic [srs_pkg::LEAF_W-1:0]               leaf_index = '0;
	logic signed [srs_pkg::OPERAND_WIDTH-1:0] operand    = '0;
	logic [srs_pkg::RANGE_W-1:0]              range_lo   = '0;
	logic [srs_pkg::RANGE_W-1:0]              range_hi   = '0;
	logic                                     out_valid;
	logic                                     out_ready  = 1'b0;
	logic signed [srs_pkg::SUM_W-1:0]         range_sum;

	int fail_count;
	int open_queries;
	int query_count;
	int sum_count;

	int items_sent   = 0;
	int burst_left   = 1;
	int cycle_count  = 0;
	int hold_asked   = 0;
	int hold_granted = 0;
	int hold_left    = 0;
	logic [7:0] rx_phase = '0;

	always #5 clk = ~clk;

	segment_tree_range_sum_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.leaf_index (leaf_index),
		.operand    (operand),
		.range_lo   (range_lo),
		.range_hi   (range_hi),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.range_sum  (range_sum)
	);

	segment_tree_range_sum_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.leaf_index   (leaf_index),
		.operand      (operand),
		.range_lo     (range_lo),
		.range_hi     (range_hi),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.range_sum    (range_sum),
		.fail_count   (fail_count),
		.open_queries (open_queries),
		.query_count  (query_count),
		.sum_count    (sum_count)
	);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("segment_tree_range_sum_unit_test: errors");
			$finish;
		end
	end

	// receiver: alternating windows of always-ready and random stalls, plus a long hold-off
	always @(posedge clk) begin
		rx_phase <= rx_phase + 8'd1;
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_granted != hold_asked) begin
			hold_granted <= hold_asked;
			hold_left    <= HOLD_CYCLES;
			out_ready    <= 1'b0;
		end else if (rx_phase[6]) begin
			out_ready <= 1'b1;
		end else if (rx_phase[7]) begin
			out_ready <= ($urandom_range(0, 5) == 0);
		end else begin
			out_ready <= ($urandom_range(0, 2) != 0);
		end
	end

	// one beat; valid stays up into the next beat unless the burst ends
	task automatic offer(input srs_pkg::func_t f, input logic [srs_pkg::LEAF_W-1:0] idx,
		input logic [srs_pkg::OPERAND_WIDTH-1:0] opnd,
		input logic [srs_pkg::RANGE_W-1:0] lo, input logic [srs_pkg::RANGE_W-1:0] hi);
		int gap;
		in_valid   <= 1'b1;
		func       <= f;
		leaf_index <= idx;
		operand    <= opnd;
		range_lo   <= lo;
		range_hi   <= hi;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
	endtask

	initial begin : stimulus
		srs_pkg::func_t                    f;
		logic [srs_pkg::LEAF_W-1:0]        idx;
		logic [srs_pkg::OPERAND_WIDTH-1:0] opnd;
		logic [srs_pkg::RANGE_W-1:0]       lo;
		logic [srs_pkg::RANGE_W-1:0]       hi;
		int                                pick;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty tree, operand extremes, clamping, empty and inverted ranges
		offer(srs_pkg::FUNC_QUERY, 10'd0, 32'd0, 11'd0, 11'd1024);
		offer(srs_pkg::FUNC_SET, 10'd0, 32'h7fff_ffff, 11'd0, 11'd0);
		offer(srs_pkg::FUNC_SET, 10'd1023, 32'h8000_0000, 11'd2047, 11'd2047);
		offer(srs_pkg::FUNC_SET, 10'd512, 32'hffff_ffff, 11'd3, 11'd9);
		offer(srs_pkg::FUNC_ADD, 10'd0, 32'h7fff_ffff, 11'd0, 11'd0);
		offer(srs_pkg::FUNC_ADD, 10'd1023, 32'h8000_0000, 11'd0, 11'd0);
		offer(srs_pkg::FUNC_QUERY, 10'd0, 32'd0, 11'd0, 11'd1024);
		offer(srs_pkg::FUNC_QUERY, 10'd1023, 32'hffff_ffff, 11'd0, 11'd1);
		offer(srs_pkg::FUNC_QUERY, 10'd0, 32'd0, 11'd1023, 11'd1024);
		offer(srs_pkg::FUNC_QUERY, 10'd0, 32'd0, 11'd1024, 11'd1024);
		offer(srs_pkg::FUNC_QUERY, 10'd0, 32'd0, 11'd5, 11'd3);
		offer(srs_pkg::FUNC_QUERY, 10'd0, 32'd0, 11'd2047, 11'd2047);
		offer(srs_pkg::FUNC_QUERY, 10'd0, 32'd0, 11'd0, 11'd2047);
		offer(srs_pkg::FUNC_QUERY, 10'd0, 32'd0, 11'd1000, 11'd2047);
		offer(srs_pkg::FUNC_QUERY, 10'd0, 32'd0, 11'd2047, 11'd0);
		offer(srs_pkg::FUNC_QUERY, 10'd0, 32'd0, 11'd512, 11'd513);
		offer(srs_pkg::FUNC_NONE, 10'd7, 32'd12345, 11'd0, 11'd1024);
		offer(srs_pkg::FUNC_QUERY, 10'd0, 32'd0, 11'd0, 11'd1024);
		offer(srs_pkg::FUNC_SET, 10'd7, 32'd0, 11'd0, 11'd0);
		offer(srs_pkg::FUNC_ADD, 10'd512, 32'd1, 11'd0, 11'd0);
		offer(srs_pkg::FUNC_QUERY, 10'd0, 32'd0, 11'd1, 11'd1023);
		offer(srs_pkg::FUNC_QUERY, 10'd0, 32'd0, 11'd511, 11'd513);

		// spread large sets over every eighth leaf so the upper nodes carry big sums
		for (int k = 0; k < 128; k++) begin
			offer(srs_pkg::FUNC_SET, srs_pkg::LEAF_W'(k * 8),
				32'h7fff_ffff - 32'($urandom_range(0, 1 << 19)),
				srs_pkg::RANGE_W'($urandom), srs_pkg::RANGE_W'($urandom));
			if (k % 32 == 31)
				offer(srs_pkg::FUNC_QUERY, srs_pkg::LEAF_W'($urandom), $urandom, 11'd0,
					srs_pkg::RANGE_W'(k * 8 + 8));
		end
		// large adds on random leaves, each followed by wide and half-tree queries
		for (int k = 0; k < 4; k++) begin
			offer(srs_pkg::FUNC_ADD, srs_pkg::LEAF_W'($urandom), 32'h7fff_ffff,
				srs_pkg::RANGE_W'($urandom), srs_pkg::RANGE_W'($urandom));
			offer(srs_pkg::FUNC_QUERY, srs_pkg::LEAF_W'($urandom), $urandom, 11'd0, 11'd1024);
			offer(srs_pkg::FUNC_QUERY, srs_pkg::LEAF_W'($urandom), $urandom, 11'd0, 11'd512);
			offer(srs_pkg::FUNC_QUERY, srs_pkg::LEAF_W'($urandom), $urandom, 11'd512, 11'd2047);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// long receiver hold-off with the sender offering back to back
			if (n == RANDOM_ITEMS / 3) begin
				hold_asked++;
				burst_left = 80;
			end
			pick = $urandom_range(0, 19);
			if (pick <= 6)
				f = srs_pkg::FUNC_SET;
			else if (pick <= 11)
				f = srs_pkg::FUNC_ADD;
			else if (pick <= 18)
				f = srs_pkg::FUNC_QUERY;
			else
				f = srs_pkg::FUNC_NONE;

			case ($urandom_range(0, 5))
				0:       idx = ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0;
				1:       idx = 10'(300 + $urandom_range(0, 7));
				default: idx = srs_pkg::LEAF_W'($urandom);
			endcase

			case ($urandom_range(0, 7))
				0:       opnd = 32'h7fff_ffff;
				1:       opnd = 32'h8000_0000;
				2:       opnd = ($urandom_range(0, 1) != 0) ? 32'hffff_ffff : 32'd0;
				3, 4:    opnd = 32'($urandom_range(0, 200)) - 32'd100;
				default: opnd = $urandom;
			endcase

			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					lo = srs_pkg::RANGE_W'($urandom_range(0, 1023));
					hi = srs_pkg::RANGE_W'($urandom_range(lo + 1, 1024));
				end
				6: begin
					lo = srs_pkg::RANGE_W'($urandom_range(0, 1024));
					hi = lo;
				end
				7: begin
					hi = srs_pkg::RANGE_W'($urandom_range(0, 1023));
					lo = srs_pkg::RANGE_W'($urandom_range(hi, 1024));
				end
				8: begin
					lo = srs_pkg::RANGE_W'($urandom_range(0, 2047));
					hi = srs_pkg::RANGE_W'($urandom_range(1024, 2047));
				end
				default: begin
					lo = srs_pkg::RANGE_W'($urandom);
					hi = srs_pkg::RANGE_W'($urandom);
				end
			endcase

			offer(f, idx, opnd, lo, hi);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (open_queries != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d items: operand extremes, clamped and empty ranges, a %0d-cycle",
			items_sent, HOLD_CYCLES);
		$display("receiver hold-off under back to back offers; %0d queries, %0d sums checked",
			query_count, sum_count);
		if (fail_count == 0)
			$display("segment_tree_range_sum_unit_test: clean");
		else
			$display("segment_tree_range_sum_unit_test: errors");
		$finish;
	end

endmodule

[files.f]
hw/rtl/srs_pkg.sv
hw/rtl/srs_node_ram.sv
hw/rtl/segment_tree_range_sum_unit.sv
tb/segment_tree_range_sum_checker.sv
tb/segment_tree_range_sum_unit_test.sv
